// ----- src/spq_pkg.sv -----
// shared types and constants for the sorted-insert priority queue
// no dependencies; imported by spq_cell and sorted_insert_priority_queue_top
package spq_pkg;

    // storage geometry
    localparam int DEPTH          = 16;
    localparam int PAYLOAD_WIDTH  = 32;
    localparam int PRIORITY_WIDTH = 8;

    // count holds 0..DEPTH, index addresses one slot
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // stream data widths, rounded up to whole bytes
    localparam int STATUS_W     = 2;
    localparam int IN_RAW_W     = PAYLOAD_WIDTH + PRIORITY_WIDTH;
    localparam int IN_DATA_W    = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W    = 3 * PAYLOAD_WIDTH + STATUS_W + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8;

    // operation kinds on s_tuser
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // broadcast to every cell in the accept cycle
    typedef struct packed {
        logic                      enq;
        logic [PAYLOAD_WIDTH-1:0]  payload;
        logic [PRIORITY_WIDTH-1:0] priority_req;
    } spq_op_t;

endpackage

// ----- src/sorted_insert_priority_queue_top.sv -----
// Sorted-insert priority queue: a row of DEPTH cells, slot 0 lowest priority.
// For each item, in the accept cycle every cell compares its priority with
// the incoming one and, on an enqueue, shifts or loads in parallel, and the
// count register moves; in the next cycle the result is formed from the
// count-indexed top slot and slot 0 into the output register. A new item is
// taken only while no result is being formed and the output register is
// empty or its result is taken in the same cycle, so the next item waits while
// the result of the last one is being formed. No clearing pass after reset.
// depends on spq_pkg and spq_cell
module sorted_insert_priority_queue_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: payload, priority_req
    input  logic [spq_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser fields from bit 0: kind
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: taken_payload, status, highest_payload,
    // lowest_payload, entry_count
    output logic [spq_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import spq_pkg::*;

    logic                      accept;
    logic                      is_deq;
    logic                      full;
    logic                      empty;
    spq_op_t                   op;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      pend_reg;
    logic [PAYLOAD_WIDTH-1:0]  taken_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     out_reg;

    logic [DEPTH-1:0]          valid_vec;
    logic [DEPTH-1:0]          gt_vec;
    logic [PAYLOAD_WIDTH-1:0]  pay_row [DEPTH];
    logic [PRIORITY_WIDTH-1:0] pri_row [DEPTH];
    logic [IDX_W-1:0]          top_idx;
    logic [PAYLOAD_WIDTH-1:0]  top_pay;
    logic [PAYLOAD_WIDTH-1:0]  high_pay;
    logic [PAYLOAD_WIDTH-1:0]  low_pay;
    logic [CNT_W-1:0]          count_dec;

    // handshake
    assign s_tready = !pend_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_deq   = (s_tuser == KIND_DEQ);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    // operation broadcast to the row
    assign op.enq          = accept && !is_deq && !full;
    assign op.payload      = s_tdata[PAYLOAD_WIDTH-1:0];
    assign op.priority_req = s_tdata[PAYLOAD_WIDTH +: PRIORITY_WIDTH];

    // row of cells; slot i is occupied when the count passes it
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign valid_vec[gi] = (count_reg > CNT_W'(gi));
            if (gi == 0) begin : g_base
                spq_cell u_cell (
                    .aclk           (aclk),
                    .op             (op),
                    .self_valid     (valid_vec[0]),
                    .below_valid    (1'b1),
                    .below_gt       (1'b0),
                    .below_payload  ('0),
                    .below_priority ('0),
                    .gt             (gt_vec[0]),
                    .payload        (pay_row[0]),
                    .priority_out   (pri_row[0])
                );
            end else begin : g_link
                spq_cell u_cell (
                    .aclk           (aclk),
                    .op             (op),
                    .self_valid     (valid_vec[gi]),
                    .below_valid    (valid_vec[gi-1]),
                    .below_gt       (gt_vec[gi-1]),
                    .below_payload  (pay_row[gi-1]),
                    .below_priority (pri_row[gi-1]),
                    .gt             (gt_vec[gi]),
                    .payload        (pay_row[gi]),
                    .priority_out   (pri_row[gi])
                );
            end
        end
    endgenerate

    // highest occupied slot, read at one address
    assign count_dec = count_reg - CNT_W'(1);
    assign top_idx   = count_dec[IDX_W-1:0];
    assign top_pay   = pay_row[top_idx];
    assign high_pay  = empty ? '0 : top_pay;
    assign low_pay   = empty ? '0 : pay_row[0];

    // count update in the accept cycle
    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (is_deq && !empty) begin
                count_next = count_dec;
            end else if (!is_deq && !full) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= accept;
            if (pend_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // taken payload and status, captured before the row changes
    always_ff @(posedge aclk) begin
        if (accept) begin
            taken_reg  <= '0;
            status_reg <= ST_OK;
            if (is_deq) begin
                if (empty) begin
                    status_reg <= ST_EMPTY;
                end else begin
                    taken_reg <= top_pay;
                end
            end else if (full) begin
                status_reg <= ST_FULL;
            end
        end
    end

    // result register, formed from the updated row
    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            out_reg <= OUT_DATA_W'({count_reg, low_pay, high_pay, status_reg, taken_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // count never exceeds the row
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // result formation only happens into a free output register
    a_pend_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !m_tvalid_reg)
        else $error("result overwrites a waiting item");

    // a dropped enqueue leaves the count alone
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_deq && full) |=> (count_reg == CNT_W'(DEPTH)))
        else $error("enqueue into full queue changed count");

    // a good dequeue lowers the count by one
    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_deq && !empty) |=> (count_reg == $past(count_dec)))
        else $error("dequeue count step wrong");

endmodule

// ----- src/spq_cell.sv -----
// one slot of the sorted chain: payload and priority plus a local compare
// depends on spq_pkg
module spq_cell (
    input  logic                               aclk,
    input  spq_pkg::spq_op_t                   op,
    input  logic                               self_valid,
    input  logic                               below_valid,
    input  logic                               below_gt,
    input  logic [spq_pkg::PAYLOAD_WIDTH-1:0]  below_payload,
    input  logic [spq_pkg::PRIORITY_WIDTH-1:0] below_priority,
    output logic                               gt,
    output logic [spq_pkg::PAYLOAD_WIDTH-1:0]  payload,
    output logic [spq_pkg::PRIORITY_WIDTH-1:0] priority_out
);
    import spq_pkg::*;

    logic [PAYLOAD_WIDTH-1:0]  payload_reg;
    logic [PRIORITY_WIDTH-1:0] priority_reg;

    // this slot outranks the incoming entry, so the entry goes below it
    assign gt = self_valid && (priority_reg > op.priority_req);

    // shift up from below, take the new entry, or hold
    always_ff @(posedge aclk) begin
        if (op.enq) begin
            if (below_gt) begin
                payload_reg  <= below_payload;
                priority_reg <= below_priority;
            end else if (gt || (!self_valid && below_valid)) begin
                payload_reg  <= op.payload;
                priority_reg <= op.priority_req;
            end
        end
    end

    assign payload      = payload_reg;
    assign priority_out = priority_reg;

endmodule

// ----- sim/tb_sorted_insert_priority_queue_top.sv -----
`timescale 1ns / 1ps
// testbench for sorted_insert_priority_queue_top: directed and random enqueue/dequeue items
// checked against an in-bench model of the sorted list; depends on spq_pkg and the rtl top
module tb_sorted_insert_priority_queue_top;
    import spq_pkg::*;

    // one expected or observed result item
    typedef struct packed {
        logic [PAYLOAD_WIDTH-1:0] taken;
        logic [STATUS_W-1:0]      status;
        logic [PAYLOAD_WIDTH-1:0] highest;
        logic [PAYLOAD_WIDTH-1:0] lowest;
        logic [CNT_W-1:0]         count;
    } queue_result_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = KIND_ENQ;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // model of the sorted list, slot 0 lowest priority
    logic [PAYLOAD_WIDTH-1:0]  model_payloads   [DEPTH];
    logic [PRIORITY_WIDTH-1:0] model_priorities [DEPTH];
    int                        model_fill = 0;

    queue_result_t pending_results [$];
    int            fail_count = 0;
    int            s_gap_max  = 5;
    int            m_gap_max  = 5;

    sorted_insert_priority_queue_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop if the run hangs
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // apply one operation to the model and return the result it should produce
    function automatic queue_result_t apply_queue_op(input logic kind,
                                                     input logic [PAYLOAD_WIDTH-1:0] pay,
                                                     input logic [PRIORITY_WIDTH-1:0] prio);
        queue_result_t r;
        int            pos;
        int            i;
        bit            found;
        r        = '0;
        r.status = ST_OK;
        if (kind == KIND_ENQ) begin
            if (model_fill >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new entry goes after every entry of equal or lower priority
                pos   = model_fill;
                found = 1'b0;
                for (i = 0; i < model_fill; i++) begin
                    if (!found && model_priorities[i] > prio) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (i = model_fill; i > pos; i--) begin
                    model_payloads[i]   = model_payloads[i-1];
                    model_priorities[i] = model_priorities[i-1];
                end
                model_payloads[pos]   = pay;
                model_priorities[pos] = prio;
                model_fill++;
            end
        end else begin
            if (model_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                model_fill--;
                r.taken = model_payloads[model_fill];
            end
        end
        if (model_fill > 0) begin
            r.highest = model_payloads[model_fill-1];
            r.lowest  = model_payloads[0];
        end
        r.count = model_fill[CNT_W-1:0];
        return r;
    endfunction

    // mostly full range, some narrow values for ties, some extremes
    function automatic logic [PRIORITY_WIDTH-1:0] pick_priority();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 2) return PRIORITY_WIDTH'($urandom_range(0, 3));
        if (sel == 2) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return PRIORITY_WIDTH'($urandom);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // send one item after a random gap and record its expected result
    task automatic send_item(input logic kind, input logic [PAYLOAD_WIDTH-1:0] pay,
                             input logic [PRIORITY_WIDTH-1:0] prio);
        int                   gap;
        logic [IN_DATA_W-1:0] word;
        queue_result_t        expected;
        gap = $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[PAYLOAD_WIDTH-1:0]            = pay;
        word[PAYLOAD_WIDTH+:PRIORITY_WIDTH] = prio;
        s_tdata  <= word;
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected = apply_queue_op(kind, pay, prio);
        pending_results.insert(pending_results.size(), expected);
    endtask

    // result side: random stalls before each item
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, m_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        queue_result_t got;
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.taken   = m_tdata[0+:PAYLOAD_WIDTH];
            got.status  = m_tdata[PAYLOAD_WIDTH+:STATUS_W];
            got.highest = m_tdata[PAYLOAD_WIDTH+STATUS_W+:PAYLOAD_WIDTH];
            got.lowest  = m_tdata[2*PAYLOAD_WIDTH+STATUS_W+:PAYLOAD_WIDTH];
            got.count   = m_tdata[3*PAYLOAD_WIDTH+STATUS_W+:CNT_W];
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result item: taken %h status %0d",
                                       got.taken, got.status));
            end else begin
                want = pending_results.pop_front();
                if (got.taken !== want.taken || got.status !== want.status ||
                    got.highest !== want.highest || got.lowest !== want.lowest ||
                    got.count !== want.count) begin
                    note_failure($sformatf({"mismatch: exp taken %h st %0d hi %h lo %h",
                                            " cnt %0d, got taken %h st %0d hi %h lo %h",
                                            " cnt %0d"},
                        want.taken, want.status, want.highest, want.lowest, want.count,
                        got.taken, got.status, got.highest, got.lowest, got.count));
                end
            end
        end
    end

    // dequeue on an empty queue right after reset
    task automatic test_empty_dequeue();
        send_item(KIND_DEQ, $urandom, PRIORITY_WIDTH'($urandom));
        send_item(KIND_DEQ, '1, '1);
    endtask

    // extreme payloads and priorities, ties leave newest first, then back to empty
    task automatic test_extremes_and_ties();
        int i;
        send_item(KIND_ENQ, '1, '1);
        send_item(KIND_ENQ, '0, '0);
        send_item(KIND_ENQ, 32'hA5A5_0001, 8'd100);
        send_item(KIND_ENQ, 32'h5A5A_0002, 8'd100);
        send_item(KIND_ENQ, 32'hC3C3_0003, 8'd100);
        send_item(KIND_ENQ, 32'h3C3C_0004, '0);
        for (i = 0; i < 6; i++) send_item(KIND_DEQ, $urandom, PRIORITY_WIDTH'($urandom));
        send_item(KIND_DEQ, '0, '0);
    endtask

    // fill to the top, push into a full queue, drain past empty
    task automatic test_fill_overflow_drain();
        int i;
        for (i = 0; i < DEPTH; i++) send_item(KIND_ENQ, $urandom, pick_priority());
        send_item(KIND_ENQ, $urandom, '1);
        send_item(KIND_ENQ, $urandom, '0);
        send_item(KIND_ENQ, $urandom, pick_priority());
        for (i = 0; i <= DEPTH; i++) send_item(KIND_DEQ, $urandom, PRIORITY_WIDTH'($urandom));
    endtask

    // random mix of operations, enqueue share in percent steers the fill level
    task automatic test_random_walk(input int n_items, input int enq_pct);
        int i;
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < enq_pct)
                send_item(KIND_ENQ, $urandom, pick_priority());
            else
                send_item(KIND_DEQ, $urandom, PRIORITY_WIDTH'($urandom));
        end
    endtask

    // reset, then run the tests in turn
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_dequeue();
        test_extremes_and_ties();
        test_fill_overflow_drain();

        // fill-heavy mix keeps the queue near full
        test_random_walk(200, 70);
        // drain-heavy mix keeps it near empty
        test_random_walk(200, 30);

        // back-to-back stretch with no idling on either side
        s_gap_max = 0;
        m_gap_max = 0;
        test_random_walk(150, 50);

        // sender idle only, then receiver idle only
        s_gap_max = 5;
        test_random_walk(100, 55);
        s_gap_max = 0;
        m_gap_max = 5;
        test_random_walk(100, 45);

        s_gap_max = 5;
        test_random_walk(120, 50);
        s_tvalid <= 1'b0;

        // let every result arrive, then a few quiet cycles
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_insert_priority_queue_top.sv
sim/tb_sorted_insert_priority_queue_top.sv
